>>> sv/flash_log_record_scanner_macros.svh
// ----------------------------------------------------------------------------
// Flash log record scanner assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef FLASH_LOG_RECORD_SCANNER_MACROS_SVH
`define FLASH_LOG_RECORD_SCANNER_MACROS_SVH

// same-cycle implication
`define FLR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("flr assertion failed");

// next-cycle implication
`define FLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("flr assertion failed");

`endif

>>> sv/flr_pkg.sv
// ----------------------------------------------------------------------------
// Flash log record scanner package
// Constants, item and result types, and the header/entry CRC-32 function.
// ----------------------------------------------------------------------------
`default_nettype none

package flr_pkg;

    localparam int ENTRY_SLOTS = 63;
    localparam int PAGE_COUNT  = 2;
    localparam int SLOT_W      = 6;
    localparam int PAGE_W      = 2;
    localparam int VALUE_W     = 7;

    localparam logic [31:0] POLY_REFL    = 32'hEDB8_8320;
    localparam logic [31:0] PAGE_MAGIC   = 32'h4E56_4D31;
    localparam logic [31:0] PAGE_COMMIT  = 32'hC0DE_C0DE;
    localparam logic [31:0] ENTRY_COMMIT = 32'hA55A_A55A;
    localparam logic [31:0] VALUE_TAG    = 32'h5AA5_0000;
    localparam logic [31:0] ERASED_WORD  = 32'hFFFF_FFFF;
    localparam logic [31:0] TAG_MASK     = 32'hFFFF_0000;
    localparam logic [7:0]  VALUE_MAX    = 8'd100;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;

    localparam logic [3:0] ST_CLEARED    = 4'd0;
    localparam logic [3:0] ST_HDR_OK     = 4'd1;
    localparam logic [3:0] ST_HDR_BAD    = 4'd2;
    localparam logic [3:0] ST_NEW_BEST   = 4'd3;
    localparam logic [3:0] ST_OLDER      = 4'd4;
    localparam logic [3:0] ST_CHECK_FAIL = 4'd5;
    localparam logic [3:0] ST_ERASED     = 4'd6;
    localparam logic [3:0] ST_BAD_COMMIT = 4'd7;
    localparam logic [3:0] ST_IGNORED    = 4'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
    } item_t;

    typedef struct packed {
        logic magic_ok;
        logic page_commit;
        logic crc_ok;
        logic payload_ok;
        logic erased;
        logic entry_commit;
    } chk_t;

    typedef struct packed {
        logic [3:0]         status;
        logic               page_ok;
        logic [SLOT_W-1:0]  next_slot;
        logic               best_valid;
        logic [31:0]        best_seq;
        logic [VALUE_W-1:0] best_value;
        logic               active_valid;
        logic               active_page;
        logic [31:0]        active_seq;
    } result_t;

    function automatic logic [31:0] crc_of_pair(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] crc;
        logic [63:0] msg;
        logic        fb;
        crc = 32'hFFFF_FFFF;
        msg = {b, a};
        for (int i = 0; i < 64; i++) begin
            fb  = crc[0] ^ msg[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ POLY_REFL;
            end
        end
        return ~crc;
    endfunction

endpackage

`default_nettype wire

>>> sv/flr_check.sv
// ----------------------------------------------------------------------------
// Flash log record scanner word checks
// Decodes magic, commit markers, erased word, CRC-32 match and tagged payload of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module flr_check (
    input  flr_pkg::item_t item,
    output flr_pkg::chk_t  chk
);
    import flr_pkg::*;

    logic [7:0] val_byte;
    logic [7:0] inv_byte;

    assign val_byte = item.word1[7:0];
    assign inv_byte = item.word1[15:8];

    always_comb begin
        chk.magic_ok     = (item.word0 == PAGE_MAGIC);
        chk.page_commit  = (item.word3 == PAGE_COMMIT);
        chk.crc_ok       = (item.word2 == crc_of_pair(item.word0, item.word1));
        chk.payload_ok   = ((item.word1 & TAG_MASK) == VALUE_TAG)
                        && (~val_byte == inv_byte)
                        && (val_byte <= VALUE_MAX);
        chk.erased       = (item.word3 == ERASED_WORD);
        chk.entry_commit = (item.word3 == ENTRY_COMMIT);
    end

endmodule

`default_nettype wire

>>> sv/flr_state.sv
// ----------------------------------------------------------------------------
// Flash log record scanner state
// Holds page, slot, newest-entry and active-page state; forms the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module flr_state (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              advance,
    input  flr_pkg::item_t   item,
    input  flr_pkg::chk_t    chk,
    output flr_pkg::result_t res_next
);
    import flr_pkg::*;

    logic [PAGE_W-1:0]  page_index_reg,  page_index_next;
    logic               page_ok_reg,     page_ok_next;
    logic               stopped_reg,     stopped_next;
    logic [SLOT_W-1:0]  slot_reg,        slot_next;
    logic               best_found_reg,  best_found_next;
    logic [31:0]        best_seq_reg,    best_seq_next;
    logic [VALUE_W-1:0] best_level_reg,  best_level_next;
    logic               act_found_reg,   act_found_next;
    logic               act_index_reg,   act_index_next;
    logic [31:0]        act_seq_reg,     act_seq_next;
    logic [3:0]         status;

    always_comb begin
        page_index_next = page_index_reg;
        page_ok_next    = page_ok_reg;
        stopped_next    = stopped_reg;
        slot_next       = slot_reg;
        best_found_next = best_found_reg;
        best_seq_next   = best_seq_reg;
        best_level_next = best_level_reg;
        act_found_next  = act_found_reg;
        act_index_next  = act_index_reg;
        act_seq_next    = act_seq_reg;
        status          = ST_IGNORED;

        unique case (item.kind)
            KIND_CLEAR: begin
                page_index_next = '0;
                page_ok_next    = 1'b0;
                stopped_next    = 1'b0;
                slot_next       = '0;
                best_found_next = 1'b0;
                best_seq_next   = '0;
                best_level_next = '0;
                act_found_next  = 1'b0;
                act_index_next  = 1'b0;
                act_seq_next    = '0;
                status          = ST_CLEARED;
            end
            KIND_HEADER: begin
                if (page_index_reg < PAGE_W'(PAGE_COUNT)) begin
                    page_index_next = page_index_reg + PAGE_W'(1);
                    slot_next       = '0;
                    if (chk.magic_ok && chk.page_commit && chk.crc_ok) begin
                        page_ok_next = 1'b1;
                        stopped_next = 1'b0;
                        if (!act_found_reg || (item.word1 > act_seq_reg)) begin
                            act_found_next = 1'b1;
                            act_index_next = page_index_reg[0];
                            act_seq_next   = item.word1;
                        end
                        status = ST_HDR_OK;
                    end else begin
                        page_ok_next = 1'b0;
                        stopped_next = 1'b1;
                        status       = ST_HDR_BAD;
                    end
                end
            end
            KIND_ENTRY: begin
                if ((page_index_reg != '0) && page_ok_reg && !stopped_reg
                        && (slot_reg < SLOT_W'(ENTRY_SLOTS))) begin
                    priority if (chk.erased) begin
                        stopped_next = 1'b1;
                        status       = ST_ERASED;
                    end else if (!chk.entry_commit) begin
                        stopped_next = 1'b1;
                        status       = ST_BAD_COMMIT;
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                        if (chk.crc_ok && chk.payload_ok) begin
                            if (!best_found_reg || (item.word0 > best_seq_reg)) begin
                                best_found_next = 1'b1;
                                best_seq_next   = item.word0;
                                best_level_next = item.word1[VALUE_W-1:0];
                                status          = ST_NEW_BEST;
                            end else begin
                                status = ST_OLDER;
                            end
                        end else begin
                            status = ST_CHECK_FAIL;
                        end
                    end
                end
            end
            default: begin
                status = ST_IGNORED;
            end
        endcase
    end

    always_comb begin
        res_next.status       = status;
        res_next.page_ok      = page_ok_next;
        res_next.next_slot    = slot_next;
        res_next.best_valid   = best_found_next;
        res_next.best_seq     = best_seq_next;
        res_next.best_value   = best_level_next;
        res_next.active_valid = act_found_next;
        res_next.active_page  = act_index_next;
        res_next.active_seq   = act_seq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_index_reg <= '0;
            page_ok_reg    <= 1'b0;
            stopped_reg    <= 1'b0;
            slot_reg       <= '0;
            best_found_reg <= 1'b0;
            best_seq_reg   <= '0;
            best_level_reg <= '0;
            act_found_reg  <= 1'b0;
            act_index_reg  <= 1'b0;
            act_seq_reg    <= '0;
        end else if (advance) begin
            page_index_reg <= page_index_next;
            page_ok_reg    <= page_ok_next;
            stopped_reg    <= stopped_next;
            slot_reg       <= slot_next;
            best_found_reg <= best_found_next;
            best_seq_reg   <= best_seq_next;
            best_level_reg <= best_level_next;
            act_found_reg  <= act_found_next;
            act_index_reg  <= act_index_next;
            act_seq_reg    <= act_seq_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/flash_log_record_scanner.sv
// An accepted s_ item passes the input register and then the result register to m_tvalid.
// Throughput: 1 item per cycle while m_tready allows; CRC-32 and state update run in the single stage between.
// s_tready stays high while the result register is empty or being taken.
// Reset: aresetn synchronous active low; clears all scan state and both valid flags.
// ----------------------------------------------------------------------------
// Flash log record scanner
// Mount-time scan of page headers and entry records of a two-page flash log.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_log_record_scanner (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [127:0] s_tdata,   // word0, word1, word2, word3
    input  wire [1:0]   s_tuser,   // kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,   // page_ok, next_slot, best_valid, best_seq,
                                   // best_value, active_valid, active_page,
                                   // active_seq, zero fill
    output logic [3:0]  m_tuser    // status
);
    import flr_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    chk_t    chk;
    result_t res_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    flr_check u_check (
        .item (in_item_reg),
        .chk  (chk)
    );

    flr_state u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (in_item_reg),
        .chk      (chk),
        .res_next (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind  <= s_tuser;
            in_item_reg.word0 <= s_tdata[31:0];
            in_item_reg.word1 <= s_tdata[63:32];
            in_item_reg.word2 <= s_tdata[95:64];
            in_item_reg.word3 <= s_tdata[127:96];
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {7'd0,
                       out_res_reg.active_seq,
                       out_res_reg.active_page,
                       out_res_reg.active_valid,
                       out_res_reg.best_value,
                       out_res_reg.best_seq,
                       out_res_reg.best_valid,
                       out_res_reg.next_slot,
                       out_res_reg.page_ok};

endmodule

`default_nettype wire

>>> sv/flr_checker.sv
// ----------------------------------------------------------------------------
// Flash log record scanner port checker
// Watches the result channel of the scanner and checks field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "flash_log_record_scanner_macros.svh"

module flr_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire [127:0] s_tdata,
    input wire [1:0]   s_tuser,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [87:0]  m_tdata,
    input wire [3:0]   m_tuser
);
    import flr_pkg::*;

    logic in_seen;
    assign in_seen = s_tvalid && s_tready && (s_tuser != KIND_CLEAR) && (s_tdata != '0);

    `FLR_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `FLR_ASSERT_IMPL(a_clear_zero, aclk, aresetn, m_tvalid && (m_tuser == ST_CLEARED) && !in_seen, m_tdata == '0)
    `FLR_ASSERT_IMPL(a_bad_page_slot, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[6:1] == '0)
    `FLR_ASSERT_IMPL(a_best_range, aclk, aresetn, m_tvalid, (m_tdata[46:40] <= 7'd100) && (m_tdata[7] || (m_tdata[39:8] == '0)))

endmodule

bind flash_log_record_scanner flr_checker u_flr_checker (.*);

`default_nettype wire
